// ===== rtl/prf_pkg.sv =====
// ----------------------------------------------------------------------------
// prf_pkg
// shared types and constants of the page replacement block
// ----------------------------------------------------------------------------
package prf_pkg;

    // result action codes
    localparam logic [1:0] ACT_HIT   = 2'd0;
    localparam logic [1:0] ACT_ALLOC = 2'd1;
    localparam logic [1:0] ACT_EVICT = 2'd2;

    // register indexes
    localparam logic REG_POLICY = 1'b0;
    localparam logic REG_PAGES  = 1'b1;

    // policy codes
    localparam logic POL_FIFO = 1'b0;
    localparam logic POL_LRU  = 1'b1;

    localparam logic [4:0] PAGES_RESET = 5'd1;
    localparam logic [4:0] MAX_ALLOC   = 5'd16;

    typedef struct packed {
        logic        policy;
        logic [4:0]  pages_per_miss;
    } cfg_t;

    typedef struct packed {
        logic [7:0]  requester;
        logic [31:0] request_total;
    } job_t;

endpackage

// ===== rtl/prf_req_if.sv =====
// ----------------------------------------------------------------------------
// prf_req_if
// request channel: one requester id per word
// ----------------------------------------------------------------------------
interface prf_req_if;
    logic       valid;
    logic       ready;
    logic [7:0] requester;

    modport source (output valid, output requester, input ready);
    modport sink   (input valid, input requester, output ready);
endinterface

// ===== rtl/prf_res_if.sv =====
// ----------------------------------------------------------------------------
// prf_res_if
// result channel: one hit, allocation or eviction event per word
// ----------------------------------------------------------------------------
interface prf_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [7:0]  owner;
    logic [31:0] request_total;
    logic [31:0] miss_total;
    logic        last;

    modport source (output valid, output action, output owner, output request_total,
                    output miss_total, output last, input ready);
    modport sink   (input valid, input action, input owner, input request_total,
                    input miss_total, input last, output ready);
endinterface

// ===== rtl/prf_cfg.sv =====
// ----------------------------------------------------------------------------
// prf_cfg
// apb register file: policy and pages per miss
// ----------------------------------------------------------------------------
module prf_cfg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output prf_pkg::cfg_t     cfg
);
    logic       policy_reg;
    logic [4:0] pages_reg;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= prf_pkg::POL_FIFO;
            pages_reg  <= prf_pkg::PAGES_RESET;
        end
        else if (wr_en)
        begin
            case (paddr[2])
                prf_pkg::REG_POLICY: policy_reg <= pwdata[0];
                prf_pkg::REG_PAGES:  pages_reg  <= pwdata[4:0];
                default:             policy_reg <= policy_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            prf_pkg::REG_POLICY: prdata = {31'd0, policy_reg};
            prf_pkg::REG_PAGES:  prdata = {27'd0, pages_reg};
            default:             prdata = 32'd0;
        endcase
    end

    assign cfg.policy         = policy_reg;
    assign cfg.pages_per_miss = pages_reg;
endmodule

// ===== rtl/prf_front.sv =====
// ----------------------------------------------------------------------------
// prf_front
// request intake: numbers each request and queues it for the engine
// ----------------------------------------------------------------------------
module prf_front (
    input  logic          clk,
    input  logic          rst_n,
    prf_req_if.sink       req,
    output prf_pkg::job_t job,
    output logic          job_valid,
    input  logic          job_ready
);
    prf_pkg::job_t q_reg [2];
    logic [31:0]   seen_reg;
    logic [1:0]    fill_reg;
    logic          wp_reg;
    logic          rp_reg;
    logic          push;
    logic          pop;

    assign req.ready = (fill_reg != 2'd2);
    assign push      = req.valid & req.ready;
    assign job_valid = (fill_reg != 2'd0);
    assign pop       = job_valid & job_ready;
    assign job       = q_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wp_reg].requester     <= req.requester;
            q_reg[wp_reg].request_total <= seen_reg + 32'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= 32'd0;
            fill_reg <= 2'd0;
            wp_reg   <= 1'b0;
            rp_reg   <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                seen_reg <= seen_reg + 32'd1;
                wp_reg   <= ~wp_reg;
            end
            if (pop)
                rp_reg <= ~rp_reg;
            if (push && !pop)
                fill_reg <= fill_reg + 2'd1;
            else if (pop && !push)
                fill_reg <= fill_reg - 2'd1;
        end
    end
endmodule

// ===== rtl/prf_back.sv =====
// ----------------------------------------------------------------------------
// prf_back
// replacement engine: frame list in insertion order, scans and result register
// ----------------------------------------------------------------------------
module prf_back #(
    parameter int FRAMES = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  prf_pkg::job_t job,
    input  logic          job_valid,
    output logic          job_ready,
    input  prf_pkg::cfg_t cfg,
    prf_res_if.source     res
);
    localparam int AW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CW = $clog2(FRAMES + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_HSCAN, S_MCHK, S_MINSCAN, S_FSCAN, S_SHIFT, S_APPEND, S_RSCAN, S_EMIT
    } state_t;

    // list storage, entry i is the i-th frame in insertion order
    logic [7:0]  owner_mem [FRAMES];
    logic [31:0] stamp_mem [FRAMES];

    state_t      state_reg;
    state_t      ret_reg;
    logic [7:0]  req_reg;
    logic [31:0] rtot_reg;
    logic [31:0] miss_reg;
    logic [31:0] tclk_reg;
    logic [CW-1:0] used_reg;
    logic [CW-1:0] iss_reg;
    logic [CW-1:0] dpos_reg;
    logic [CW-1:0] vpos_reg;
    logic        dv_reg;
    logic        hit_reg;
    logic [31:0] min_reg;
    logic [7:0]  minown_reg;
    logic        minset_reg;
    logic [7:0]  who_reg;
    logic        found_reg;
    logic [7:0]  gone_reg;
    logic [4:0]  k_reg;
    logic [4:0]  cnt_reg;
    logic [1:0]  eact_reg;
    logic [7:0]  eown_reg;
    logic        elast_reg;
    logic        ov_reg;
    logic [1:0]  oact_reg;
    logic [7:0]  oown_reg;
    logic [31:0] ortot_reg;
    logic [31:0] omiss_reg;
    logic        olast_reg;
    logic [7:0]  rd_own;
    logic [31:0] rd_stamp;

    logic          scanning;
    logic          issue;
    logic          done;
    logic          match;
    logic [AW-1:0] rd_addr;
    logic          own_we;
    logic          st_we;
    logic [AW-1:0] wr_addr;
    logic [7:0]    own_wd;
    logic [31:0]   st_wd;
    logic [4:0]    cnt_next;
    logic          lastalloc;

    assign scanning = (state_reg == S_HSCAN) || (state_reg == S_MINSCAN) ||
                      (state_reg == S_FSCAN) || (state_reg == S_RSCAN) ||
                      (state_reg == S_SHIFT);
    assign issue    = scanning && (iss_reg < used_reg);
    assign done     = !issue && !dv_reg;
    assign match    = (rd_own == req_reg);
    assign rd_addr  = issue ? iss_reg[AW-1:0] : '0;
    assign lastalloc = (k_reg == cnt_reg - 5'd1);

    always_comb
    begin
        if (cfg.pages_per_miss == 5'd0)
            cnt_next = 5'd1;
        else if (cfg.pages_per_miss > prf_pkg::MAX_ALLOC)
            cnt_next = prf_pkg::MAX_ALLOC;
        else
            cnt_next = cfg.pages_per_miss;
    end

    always_comb
    begin
        own_we  = 1'b0;
        st_we   = 1'b0;
        wr_addr = dpos_reg[AW-1:0];
        own_wd  = rd_own;
        st_wd   = tclk_reg;
        case (state_reg)
            S_HSCAN, S_RSCAN:
            begin
                st_we = dv_reg && match && (cfg.policy == prf_pkg::POL_LRU);
            end
            S_SHIFT:
            begin
                own_we  = dv_reg;
                st_we   = dv_reg;
                wr_addr = dpos_reg[AW-1:0] - AW'(1);
                st_wd   = rd_stamp;
            end
            S_APPEND:
            begin
                own_we  = 1'b1;
                st_we   = 1'b1;
                wr_addr = used_reg[AW-1:0];
                own_wd  = req_reg;
                st_wd   = 32'd0;
            end
            default:
            begin
                own_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (own_we)
            owner_mem[wr_addr] <= own_wd;
        if (st_we)
            stamp_mem[wr_addr] <= st_wd;
        rd_own   <= owner_mem[rd_addr];
        rd_stamp <= stamp_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ret_reg    <= S_IDLE;
            miss_reg   <= 32'd0;
            tclk_reg   <= 32'd0;
            used_reg   <= '0;
            iss_reg    <= '0;
            dpos_reg   <= '0;
            vpos_reg   <= '0;
            dv_reg     <= 1'b0;
            hit_reg    <= 1'b0;
            minset_reg <= 1'b0;
            found_reg  <= 1'b0;
            k_reg      <= 5'd0;
            cnt_reg    <= 5'd1;
            ov_reg     <= 1'b0;
            req_reg    <= 8'd0;
            rtot_reg   <= 32'd0;
            min_reg    <= 32'd0;
            minown_reg <= 8'd0;
            who_reg    <= 8'd0;
            gone_reg   <= 8'd0;
            eact_reg   <= prf_pkg::ACT_HIT;
            eown_reg   <= 8'd0;
            elast_reg  <= 1'b0;
            oact_reg   <= prf_pkg::ACT_HIT;
            oown_reg   <= 8'd0;
            ortot_reg  <= 32'd0;
            omiss_reg  <= 32'd0;
            olast_reg  <= 1'b0;
        end
        else
        begin
            dv_reg   <= issue;
            dpos_reg <= iss_reg;
            if (issue)
                iss_reg <= iss_reg + CW'(1);
            if (ov_reg && res.ready)
                ov_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (job_valid)
                    begin
                        req_reg   <= job.requester;
                        rtot_reg  <= job.request_total;
                        cnt_reg   <= cnt_next;
                        iss_reg   <= '0;
                        hit_reg   <= 1'b0;
                        k_reg     <= 5'd0;
                        state_reg <= S_HSCAN;
                    end
                end
                S_HSCAN:
                begin
                    if (dv_reg && match)
                    begin
                        hit_reg <= 1'b1;
                        if (cfg.policy == prf_pkg::POL_LRU)
                            tclk_reg <= tclk_reg + 32'd1;
                    end
                    if (done)
                    begin
                        if (hit_reg)
                        begin
                            eact_reg  <= prf_pkg::ACT_HIT;
                            eown_reg  <= req_reg;
                            elast_reg <= 1'b1;
                            ret_reg   <= S_IDLE;
                            state_reg <= S_EMIT;
                        end
                        else
                        begin
                            miss_reg  <= miss_reg + 32'd1;
                            state_reg <= S_MCHK;
                        end
                    end
                end
                S_MCHK:
                begin
                    iss_reg    <= '0;
                    minset_reg <= 1'b0;
                    found_reg  <= 1'b0;
                    if (used_reg == CW'(FRAMES))
                        state_reg <= (cfg.policy == prf_pkg::POL_LRU) ? S_MINSCAN : S_FSCAN;
                    else
                        state_reg <= S_APPEND;
                end
                S_MINSCAN:
                begin
                    if (dv_reg && (!minset_reg || rd_stamp < min_reg))
                    begin
                        min_reg    <= rd_stamp;
                        minown_reg <= rd_own;
                        minset_reg <= 1'b1;
                    end
                    if (done)
                    begin
                        who_reg   <= minown_reg;
                        iss_reg   <= '0;
                        state_reg <= S_FSCAN;
                    end
                end
                S_FSCAN:
                begin
                    // fifo takes the head, lru the first frame of the victim owner
                    if (dv_reg && !found_reg &&
                        (cfg.policy == prf_pkg::POL_FIFO || rd_own == who_reg))
                    begin
                        found_reg <= 1'b1;
                        vpos_reg  <= dpos_reg;
                        gone_reg  <= rd_own;
                    end
                    if (done)
                    begin
                        iss_reg   <= vpos_reg + CW'(1);
                        state_reg <= S_SHIFT;
                    end
                end
                S_SHIFT:
                begin
                    if (done)
                    begin
                        used_reg  <= used_reg - CW'(1);
                        eact_reg  <= prf_pkg::ACT_EVICT;
                        eown_reg  <= gone_reg;
                        elast_reg <= 1'b0;
                        ret_reg   <= S_APPEND;
                        state_reg <= S_EMIT;
                    end
                end
                S_APPEND:
                begin
                    used_reg <= used_reg + CW'(1);
                    iss_reg  <= '0;
                    if (cfg.policy == prf_pkg::POL_LRU)
                        state_reg <= S_RSCAN;
                    else
                    begin
                        eact_reg  <= prf_pkg::ACT_ALLOC;
                        eown_reg  <= req_reg;
                        elast_reg <= lastalloc;
                        ret_reg   <= lastalloc ? S_IDLE : S_MCHK;
                        k_reg     <= k_reg + 5'd1;
                        state_reg <= S_EMIT;
                    end
                end
                S_RSCAN:
                begin
                    if (dv_reg && match)
                        tclk_reg <= tclk_reg + 32'd1;
                    if (done)
                    begin
                        eact_reg  <= prf_pkg::ACT_ALLOC;
                        eown_reg  <= req_reg;
                        elast_reg <= lastalloc;
                        ret_reg   <= lastalloc ? S_IDLE : S_MCHK;
                        k_reg     <= k_reg + 5'd1;
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    if (!ov_reg || res.ready)
                    begin
                        ov_reg    <= 1'b1;
                        oact_reg  <= eact_reg;
                        oown_reg  <= eown_reg;
                        ortot_reg <= rtot_reg;
                        omiss_reg <= miss_reg;
                        olast_reg <= elast_reg;
                        state_reg <= ret_reg;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign job_ready         = (state_reg == S_IDLE);
    assign res.valid         = ov_reg;
    assign res.action        = oact_reg;
    assign res.owner         = oown_reg;
    assign res.request_total = ortot_reg;
    assign res.miss_total    = omiss_reg;
    assign res.last          = olast_reg;

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= CW'(FRAMES))
        else $error("frame list overfilled");

    a_evict_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MINSCAN || state_reg == S_FSCAN || state_reg == S_SHIFT)
        |-> used_reg == CW'(FRAMES))
        else $error("eviction with free frames");

    a_victim_found: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FSCAN && done) |-> found_reg)
        else $error("no victim located");

    a_miss_source: assert property (@(posedge clk) disable iff (!rst_n)
        (miss_reg != $past(miss_reg)) |-> ($past(state_reg) == S_HSCAN && !$past(hit_reg)))
        else $error("miss count moved outside lookup");
endmodule

// ===== rtl/page_replacement_fifo_lru_top.sv =====
// ----------------------------------------------------------------------------
// page_replacement_fifo_lru_top
// page frame replacement unit, fifo or lru, with apb configuration
// ----------------------------------------------------------------------------
//  channel | dir | handshake         | word
//  --------+-----+-------------------+----------------------------------------
//  req     | in  | valid / ready     | requester
//  res     | out | valid / ready     | action, owner, request_total,
//          |     |                   | miss_total, last
//  apb     | in  | psel/penable, rdy | policy (0x0), pages_per_miss (0x4)
//
//  a hit takes one pass over the frame list, one memory read per cycle;
//  each allocated frame on a miss adds a restamp pass under lru; when the
//  list is full an eviction also adds a min-stamp pass (lru), an owner
//  search pass and a list shift pass
//  reset clears the list count, counters and the policy registers at once;
//  no clearing pass
//  a two-word queue in front takes requests while the engine works, and the
//  result register lets the engine park until the sink takes the word
// ----------------------------------------------------------------------------
module page_replacement_fifo_lru_top #(
    parameter int FRAMES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    prf_req_if.sink     req,
    prf_res_if.source   res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    prf_pkg::cfg_t cfg;
    prf_pkg::job_t job;
    logic          job_valid;
    logic          job_ready;

    // register file
    prf_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // intake: numbers requests, holds up to two
    prf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .job       (job),
        .job_valid (job_valid),
        .job_ready (job_ready)
    );

    // engine: lookup, eviction, allocation and result register
    prf_back #(
        .FRAMES (FRAMES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (job),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .cfg       (cfg),
        .res       (res)
    );
endmodule
